@@ design/lob_pkg.sv @@
package lob_pkg;

  localparam int unsigned MAX_ORDERS = 32;
  localparam int unsigned IDX_W = $clog2(MAX_ORDERS);
  localparam int unsigned CNT_W = $clog2(MAX_ORDERS + 1);
  localparam int unsigned SUM_W = 32 + CNT_W;

  localparam logic [1:0] OP_SUBMIT  = 2'd0;
  localparam logic [1:0] OP_CANCEL  = 2'd1;
  localparam logic [1:0] OP_REPLACE = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  localparam logic [2:0] OT_LIMIT     = 3'd0;
  localparam logic [2:0] OT_MARKET    = 3'd1;
  localparam logic [2:0] OT_IOC       = 3'd2;
  localparam logic [2:0] OT_FOK       = 3'd3;
  localparam logic [2:0] OT_POST_ONLY = 3'd4;
  localparam logic [2:0] OT_RSVD_LO   = 3'd5;
  localparam logic [2:0] OT_RSVD_HI   = 3'd7;

  localparam logic [1:0] EV_ACK    = 2'd0;
  localparam logic [1:0] EV_REJECT = 2'd1;
  localparam logic [1:0] EV_CANCEL = 2'd2;
  localparam logic [1:0] EV_FILL   = 2'd3;

  localparam logic [2:0] ST_NEW       = 3'd0;
  localparam logic [2:0] ST_PARTIAL   = 3'd1;
  localparam logic [2:0] ST_FILLED    = 3'd2;
  localparam logic [2:0] ST_CANCELLED = 3'd3;
  localparam logic [2:0] ST_REJECTED  = 3'd4;

  localparam logic [2:0] RR_NONE      = 3'd0;
  localparam logic [2:0] RR_DUPLICATE = 3'd0;
  localparam logic [2:0] RR_POST_CROSS = 3'd1;
  localparam logic [2:0] RR_FOK       = 3'd2;
  localparam logic [2:0] RR_UNKNOWN   = 3'd3;
  localparam logic [2:0] RR_BOOK_FULL = 3'd5;

  typedef struct packed {
    logic [31:0] cid;
    logic [15:0] owner;
    logic        side;
    logic [19:0] price;
    logic [31:0] size;
    logic [31:0] filled;
    logic        passive;
    logic [31:0] arrival;
  } slot_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] cid;
    logic [31:0] maker;
    logic [19:0] price;
    logic [31:0] qty;
    logic        tside;
    logic [2:0]  status;
    logic [2:0]  reason;
    logic        last;
  } ev_t;

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_FIND   = 14'b00000000000010,
    S_FDEC   = 14'b00000000000100,
    S_POSCAN = 14'b00000000001000,
    S_PODEC  = 14'b00000000010000,
    S_LIQ    = 14'b00000000100000,
    S_LDEC   = 14'b00000001000000,
    S_MLOOP  = 14'b00000010000000,
    S_MSCAN  = 14'b00000100000000,
    S_MDEC   = 14'b00001000000000,
    S_MFILL  = 14'b00010000000000,
    S_POST   = 14'b00100000000000,
    S_EMIT   = 14'b01000000000000,
    S_SPARE  = 14'b10000000000000
  } state_t;

  function automatic logic crosses(input logic side, input logic priced,
                                   input logic [19:0] limit, input logic [19:0] rest);
    if (!priced) return 1'b1;
    return side ? (limit <= rest) : (limit >= rest);
  endfunction

  function automatic ev_t mk_ev(input logic [1:0] kind, input logic [31:0] cid,
                                input logic [31:0] maker, input logic [19:0] price,
                                input logic [31:0] qty, input logic tside,
                                input logic [2:0] status, input logic [2:0] reason,
                                input logic last);
    ev_t e;
    e.kind = kind;
    e.cid = cid;
    e.maker = maker;
    e.price = price;
    e.qty = qty;
    e.tside = tside;
    e.status = status;
    e.reason = reason;
    e.last = last;
    return e;
  endfunction

endpackage

@@ design/limit_order_book_matcher_core.sv @@
// A request walks the order store with one full scan per lookup, per post-only or
// fill-or-kill check and per matched maker, and each event waits in S_EMIT while
// out_stall holds the output. Only one request is taken at a time; the single read
// port of the order store is walked by the scan counter.
// Reset (rst_n low, synchronous) clears all slot valid bits, the sequence counter
// and the output valid flag; the store contents need no clearing.
module limit_order_book_matcher_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_client_id,
  input  logic [31:0] in_new_client_id,
  input  logic [15:0] in_participant,
  input  logic        in_side,
  input  logic [2:0]  in_order_type,
  input  logic [19:0] in_price,
  input  logic        in_price_given,
  input  logic [31:0] in_quantity,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_event_kind,
  output logic [31:0] out_event_seq,
  output logic [31:0] out_event_client_id,
  output logic [31:0] out_maker_id,
  output logic [19:0] out_trade_price,
  output logic [31:0] out_trade_quantity,
  output logic        out_aggressor_side,
  output logic [2:0]  out_order_status,
  output logic [2:0]  out_reject_reason,
  output logic        out_last
);

  localparam int unsigned N  = lob_pkg::MAX_ORDERS;
  localparam int unsigned IW = lob_pkg::IDX_W;
  localparam int unsigned CW = lob_pkg::CNT_W;
  localparam int unsigned SW = lob_pkg::SUM_W;

  lob_pkg::slot_t  slot_mem_r [N];
  lob_pkg::slot_t  rd_q_r;
  logic [IW-1:0]   rd_addr;
  logic            mem_we;
  logic [IW-1:0]   mem_wa;
  lob_pkg::slot_t  mem_wd;

  lob_pkg::state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [N-1:0]    vld_r, vld_nxt;
  logic [31:0]     seq_r, seq_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  logic [1:0]      op_r, op_nxt;
  logic [31:0]     cid_r, cid_nxt, ncid_r, ncid_nxt;
  logic [15:0]     part_r, part_nxt;
  logic            side_r, side_nxt, po_r, po_nxt, fok_r, fok_nxt, rest_r, rest_nxt;
  logic            priced_r, priced_nxt;
  logic [19:0]     price_r, price_nxt;
  logic [31:0]     qty_r, qty_nxt, filled_r, filled_nxt, arr_r, arr_nxt, t_r, t_nxt;

  logic            ff_r, ff_nxt, bf_r, bf_nxt;
  logic [IW-1:0]   fidx_r, fidx_nxt, bidx_r, bidx_nxt;
  lob_pkg::slot_t  fr_r, fr_nxt, b_r, b_nxt;
  logic [31:0]     bage_r, bage_nxt;
  logic [SW-1:0]   sum_r, sum_nxt;

  lob_pkg::ev_t    ev_r, ev_nxt, out_r, out_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [31:0]     out_seq_r, out_seq_nxt;

  logic [IW-1:0]   eidx;
  logic            e_vld, e_cand, better, scan_end, free_any, out_free;
  logic [IW-1:0]   free_idx;
  logic [31:0]     age, mrem, need, nf;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem_r[mem_wa] <= mem_wd;
    end
    rd_q_r <= slot_mem_r[rd_addr];
  end

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!vld_r[i]) begin
        free_any = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  assign rd_addr  = (cnt_r < CW'(N)) ? cnt_r[IW-1:0] : '0;
  assign eidx     = IW'(cnt_r - CW'(1));
  assign e_vld    = (cnt_r != '0) && vld_r[eidx];
  assign e_cand   = e_vld && (rd_q_r.side != side_r);
  assign scan_end = (cnt_r == CW'(N));
  assign age      = seq_r - rd_q_r.arrival;
  assign better   = !bf_r ||
                    ((rd_q_r.price != b_r.price) ?
                       (side_r ? (rd_q_r.price > b_r.price) : (rd_q_r.price < b_r.price)) :
                       (age > bage_r));
  assign mrem     = b_r.size - b_r.filled;
  assign need     = qty_r - filled_r;
  assign nf       = b_r.filled + t_r;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    ret_nxt = ret_r;
    vld_nxt = vld_r;
    seq_nxt = seq_r;
    cnt_nxt = '0;
    op_nxt = op_r;
    cid_nxt = cid_r;
    ncid_nxt = ncid_r;
    part_nxt = part_r;
    side_nxt = side_r;
    po_nxt = po_r;
    fok_nxt = fok_r;
    rest_nxt = rest_r;
    priced_nxt = priced_r;
    price_nxt = price_r;
    qty_nxt = qty_r;
    filled_nxt = filled_r;
    arr_nxt = arr_r;
    t_nxt = t_r;
    ff_nxt = ff_r;
    bf_nxt = bf_r;
    fidx_nxt = fidx_r;
    bidx_nxt = bidx_r;
    fr_nxt = fr_r;
    b_nxt = b_r;
    bage_nxt = bage_r;
    sum_nxt = sum_r;
    ev_nxt = ev_r;
    out_nxt = out_r;
    out_seq_nxt = out_seq_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = b_r;

    unique case (state_r)
      lob_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt = in_op;
          cid_nxt = in_client_id;
          ncid_nxt = in_new_client_id;
          part_nxt = in_participant;
          side_nxt = in_side;
          po_nxt = (in_order_type == lob_pkg::OT_POST_ONLY);
          fok_nxt = (in_order_type == lob_pkg::OT_FOK);
          rest_nxt = (in_order_type == lob_pkg::OT_LIMIT) ||
                     (in_order_type >= lob_pkg::OT_POST_ONLY);
          priced_nxt = in_price_given;
          price_nxt = in_price;
          qty_nxt = in_quantity;
          filled_nxt = '0;
          if (in_op == lob_pkg::OP_SUBMIT || in_op == lob_pkg::OP_CANCEL ||
              in_op == lob_pkg::OP_REPLACE) begin
            state_nxt = lob_pkg::S_FIND;
          end
        end
      end
      lob_pkg::S_FIND: begin
        if (cnt_r == '0) begin
          ff_nxt = 1'b0;
        end else if (e_vld && rd_q_r.cid == cid_r) begin
          ff_nxt = 1'b1;
          fidx_nxt = eidx;
          fr_nxt = rd_q_r;
        end
        if (scan_end) state_nxt = lob_pkg::S_FDEC;
        else cnt_nxt = cnt_r + CW'(1);
      end
      lob_pkg::S_FDEC: begin
        state_nxt = lob_pkg::S_EMIT;
        ret_nxt = lob_pkg::S_IDLE;
        if (op_r == lob_pkg::OP_SUBMIT) begin
          if (ff_r) begin
            ev_nxt = lob_pkg::mk_ev(lob_pkg::EV_REJECT, cid_r, '0, '0, '0, 1'b0,
                                    lob_pkg::ST_REJECTED, lob_pkg::RR_DUPLICATE, 1'b1);
          end else if (po_r) begin
            state_nxt = lob_pkg::S_POSCAN;
          end else if (fok_r) begin
            state_nxt = lob_pkg::S_LIQ;
          end else begin
            seq_nxt = seq_r + 32'd1;
            arr_nxt = seq_r + 32'd1;
            state_nxt = lob_pkg::S_MLOOP;
          end
        end else if (!ff_r || fr_r.owner != part_r) begin
          ev_nxt = lob_pkg::mk_ev(lob_pkg::EV_REJECT, cid_r, '0, '0, '0, 1'b0,
                                  lob_pkg::ST_REJECTED, lob_pkg::RR_UNKNOWN, 1'b1);
        end else if (op_r == lob_pkg::OP_CANCEL) begin
          vld_nxt[fidx_r] = 1'b0;
          ev_nxt = lob_pkg::mk_ev(lob_pkg::EV_CANCEL, cid_r, '0, '0, '0, 1'b0,
                                  lob_pkg::ST_CANCELLED, lob_pkg::RR_NONE, 1'b1);
        end else if ((!priced_r || price_r == fr_r.price) && qty_r > fr_r.filled &&
                     qty_r <= fr_r.size) begin
          mem_we = 1'b1;
          mem_wa = fidx_r;
          mem_wd = fr_r;
          mem_wd.size = qty_r;
          ev_nxt = lob_pkg::mk_ev(lob_pkg::EV_ACK, cid_r, '0, '0, '0, 1'b0,
                                  (fr_r.filled != '0) ? lob_pkg::ST_PARTIAL : lob_pkg::ST_NEW,
                                  lob_pkg::RR_NONE, 1'b1);
        end else begin
          vld_nxt[fidx_r] = 1'b0;
          ev_nxt = lob_pkg::mk_ev(lob_pkg::EV_CANCEL, cid_r, '0, '0, '0, 1'b0,
                                  lob_pkg::ST_CANCELLED, lob_pkg::RR_NONE, 1'b0);
          ret_nxt = lob_pkg::S_FIND;
          op_nxt = lob_pkg::OP_SUBMIT;
          cid_nxt = ncid_r;
          side_nxt = fr_r.side;
          po_nxt = fr_r.passive;
          fok_nxt = 1'b0;
          rest_nxt = 1'b1;
          priced_nxt = 1'b1;
          price_nxt = priced_r ? price_r : fr_r.price;
        end
      end
      lob_pkg::S_POSCAN, lob_pkg::S_MSCAN: begin
        if (cnt_r == '0) begin
          bf_nxt = 1'b0;
        end else if (e_cand && better) begin
          bf_nxt = 1'b1;
          bidx_nxt = eidx;
          b_nxt = rd_q_r;
          bage_nxt = age;
        end
        if (scan_end) begin
          state_nxt = (state_r == lob_pkg::S_POSCAN) ? lob_pkg::S_PODEC : lob_pkg::S_MDEC;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      lob_pkg::S_PODEC: begin
        if (bf_r && lob_pkg::crosses(side_r, priced_r, price_r, b_r.price)) begin
          ev_nxt = lob_pkg::mk_ev(lob_pkg::EV_REJECT, cid_r, '0, '0, '0, 1'b0,
                                  lob_pkg::ST_REJECTED, lob_pkg::RR_POST_CROSS, 1'b1);
          ret_nxt = lob_pkg::S_IDLE;
          state_nxt = lob_pkg::S_EMIT;
        end else begin
          seq_nxt = seq_r + 32'd1;
          arr_nxt = seq_r + 32'd1;
          state_nxt = lob_pkg::S_POST;
        end
      end
      lob_pkg::S_LIQ: begin
        if (cnt_r == '0) begin
          sum_nxt = '0;
        end else if (e_cand && rd_q_r.owner != part_r &&
                     lob_pkg::crosses(side_r, priced_r, price_r, rd_q_r.price)) begin
          sum_nxt = sum_r + SW'(rd_q_r.size - rd_q_r.filled);
        end
        if (scan_end) state_nxt = lob_pkg::S_LDEC;
        else cnt_nxt = cnt_r + CW'(1);
      end
      lob_pkg::S_LDEC: begin
        if (sum_r < SW'(qty_r)) begin
          ev_nxt = lob_pkg::mk_ev(lob_pkg::EV_REJECT, cid_r, '0, '0, '0, 1'b0,
                                  lob_pkg::ST_REJECTED, lob_pkg::RR_FOK, 1'b1);
          ret_nxt = lob_pkg::S_IDLE;
          state_nxt = lob_pkg::S_EMIT;
        end else begin
          seq_nxt = seq_r + 32'd1;
          arr_nxt = seq_r + 32'd1;
          state_nxt = lob_pkg::S_MLOOP;
        end
      end
      lob_pkg::S_MLOOP: begin
        state_nxt = (filled_r < qty_r) ? lob_pkg::S_MSCAN : lob_pkg::S_POST;
      end
      lob_pkg::S_MDEC: begin
        if (!bf_r || !lob_pkg::crosses(side_r, priced_r, price_r, b_r.price)) begin
          state_nxt = lob_pkg::S_POST;
        end else if (b_r.owner == part_r) begin
          vld_nxt[bidx_r] = 1'b0;
          ev_nxt = lob_pkg::mk_ev(lob_pkg::EV_CANCEL, b_r.cid, '0, '0, '0, 1'b0,
                                  lob_pkg::ST_CANCELLED, lob_pkg::RR_NONE, 1'b0);
          ret_nxt = lob_pkg::S_MLOOP;
          state_nxt = lob_pkg::S_EMIT;
        end else begin
          t_nxt = (mrem < need) ? mrem : need;
          state_nxt = lob_pkg::S_MFILL;
        end
      end
      lob_pkg::S_MFILL: begin
        mem_we = 1'b1;
        mem_wa = bidx_r;
        mem_wd = b_r;
        mem_wd.filled = nf;
        if (nf == b_r.size) vld_nxt[bidx_r] = 1'b0;
        filled_nxt = filled_r + t_r;
        ev_nxt = lob_pkg::mk_ev(lob_pkg::EV_FILL, cid_r, b_r.cid, b_r.price, t_r, side_r,
                                lob_pkg::ST_NEW, lob_pkg::RR_NONE, 1'b0);
        ret_nxt = lob_pkg::S_MLOOP;
        state_nxt = lob_pkg::S_EMIT;
      end
      lob_pkg::S_POST: begin
        ret_nxt = lob_pkg::S_IDLE;
        state_nxt = lob_pkg::S_EMIT;
        if (filled_r == qty_r) begin
          ev_nxt = lob_pkg::mk_ev(lob_pkg::EV_ACK, cid_r, '0, '0, '0, 1'b0,
                                  lob_pkg::ST_FILLED, lob_pkg::RR_NONE, 1'b1);
        end else if (rest_r && priced_r) begin
          if (!free_any) begin
            ev_nxt = lob_pkg::mk_ev(lob_pkg::EV_REJECT, cid_r, '0, '0, '0, 1'b0,
                                    lob_pkg::ST_REJECTED, lob_pkg::RR_BOOK_FULL, 1'b1);
          end else begin
            mem_we = 1'b1;
            mem_wa = free_idx;
            mem_wd.cid = cid_r;
            mem_wd.owner = part_r;
            mem_wd.side = side_r;
            mem_wd.price = price_r;
            mem_wd.size = qty_r;
            mem_wd.filled = filled_r;
            mem_wd.passive = po_r;
            mem_wd.arrival = arr_r;
            vld_nxt[free_idx] = 1'b1;
            ev_nxt = lob_pkg::mk_ev(lob_pkg::EV_ACK, cid_r, '0, '0, '0, 1'b0,
                                    (filled_r != '0) ? lob_pkg::ST_PARTIAL : lob_pkg::ST_NEW,
                                    lob_pkg::RR_NONE, 1'b1);
          end
        end else begin
          ev_nxt = lob_pkg::mk_ev(lob_pkg::EV_CANCEL, cid_r, '0, '0, '0, 1'b0,
                                  lob_pkg::ST_CANCELLED, lob_pkg::RR_NONE, 1'b1);
        end
      end
      lob_pkg::S_EMIT: begin
        if (out_free) begin
          out_nxt = ev_r;
          out_seq_nxt = seq_r + 32'd1;
          seq_nxt = seq_r + 32'd1;
          out_valid_nxt = 1'b1;
          state_nxt = ret_r;
        end
      end
      default: begin
        state_nxt = lob_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lob_pkg::S_IDLE;
      ret_r <= lob_pkg::S_IDLE;
      vld_r <= '0;
      seq_r <= '0;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r <= ret_nxt;
      vld_r <= vld_nxt;
      seq_r <= seq_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    cid_r <= cid_nxt;
    ncid_r <= ncid_nxt;
    part_r <= part_nxt;
    side_r <= side_nxt;
    po_r <= po_nxt;
    fok_r <= fok_nxt;
    rest_r <= rest_nxt;
    priced_r <= priced_nxt;
    price_r <= price_nxt;
    qty_r <= qty_nxt;
    filled_r <= filled_nxt;
    arr_r <= arr_nxt;
    t_r <= t_nxt;
    ff_r <= ff_nxt;
    bf_r <= bf_nxt;
    fidx_r <= fidx_nxt;
    bidx_r <= bidx_nxt;
    fr_r <= fr_nxt;
    b_r <= b_nxt;
    bage_r <= bage_nxt;
    sum_r <= sum_nxt;
    ev_r <= ev_nxt;
    out_r <= out_nxt;
    out_seq_r <= out_seq_nxt;
  end

  assign in_stall            = (state_r != lob_pkg::S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_event_kind      = out_r.kind;
  assign out_event_seq       = out_seq_r;
  assign out_event_client_id = out_r.cid;
  assign out_maker_id        = out_r.maker;
  assign out_trade_price     = out_r.price;
  assign out_trade_quantity  = out_r.qty;
  assign out_aggressor_side  = out_r.tside;
  assign out_order_status    = out_r.status;
  assign out_reject_reason   = out_r.reason;
  assign out_last            = out_r.last;

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");

  a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lob_pkg::S_EMIT && out_free) |=> (seq_r == $past(seq_r) + 32'd1))
    else $error("sequence did not advance on event");

  a_fill_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.kind == lob_pkg::EV_FILL) |-> (out_r.qty != '0))
    else $error("fill with zero quantity");

  a_fill_has_maker: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lob_pkg::S_MFILL) |-> (bf_r && vld_r[bidx_r]))
    else $error("fill without a valid maker");
`endif

endmodule

@@ dv/limit_order_book_matcher_core_tb.sv @@
`timescale 1ns / 1ps
module limit_order_book_matcher_core_tb;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] cid;
    logic [31:0] ncid;
    logic [15:0] part;
    logic        side;
    logic [2:0]  otype;
    logic [19:0] price;
    logic        priced;
    logic [31:0] qty;
  } request_t;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] seq;
    logic [31:0] cid;
    logic [31:0] maker;
    logic [19:0] price;
    logic [31:0] qty;
    logic        tside;
    logic [2:0]  status;
    logic [2:0]  reason;
    logic        last;
  } book_event_t;

  class book_scoreboard;
    logic        bk_valid[lob_pkg::MAX_ORDERS];
    logic [31:0] bk_cid[lob_pkg::MAX_ORDERS];
    logic [15:0] bk_owner[lob_pkg::MAX_ORDERS];
    logic        bk_side[lob_pkg::MAX_ORDERS];
    logic [19:0] bk_price[lob_pkg::MAX_ORDERS];
    logic [31:0] bk_size[lob_pkg::MAX_ORDERS];
    logic [31:0] bk_filled[lob_pkg::MAX_ORDERS];
    logic        bk_post[lob_pkg::MAX_ORDERS];
    logic [31:0] bk_arrival[lob_pkg::MAX_ORDERS];
    logic [31:0] seq_count;
    book_event_t pending_events[$];
    int          batch;
    int          errors;

    function new();
      for (int i = 0; i < lob_pkg::MAX_ORDERS; i++) bk_valid[i] = 1'b0;
      seq_count = '0;
      errors = 0;
    endfunction

    function void push_event(logic [1:0] k, logic [31:0] c, logic [31:0] m,
                             logic [19:0] p, logic [31:0] q, logic t,
                             logic [2:0] st, logic [2:0] rr);
      book_event_t e;
      if (batch >= 64) return;
      seq_count++;
      e.kind = k; e.seq = seq_count; e.cid = c; e.maker = m; e.price = p;
      e.qty = q; e.tside = t; e.status = st; e.reason = rr; e.last = 1'b0;
      pending_events.insert(pending_events.size(), e);
      batch++;
    endfunction

    function int lookup(logic [31:0] c);
      for (int i = 0; i < lob_pkg::MAX_ORDERS; i++)
        if (bk_valid[i] && bk_cid[i] == c) return i;
      return -1;
    endfunction

    function logic does_cross(logic s, logic pr, logic [19:0] lim, logic [19:0] r);
      if (!pr) return 1'b1;
      return s ? (lim <= r) : (lim >= r);
    endfunction

    function int best_maker(logic s);
      int b;
      b = -1;
      for (int i = 0; i < lob_pkg::MAX_ORDERS; i++) begin
        if (!bk_valid[i] || bk_side[i] == s) continue;
        if (b < 0) begin
          b = i;
        end else if (bk_price[i] != bk_price[b]) begin
          if (s ? bk_price[i] > bk_price[b] : bk_price[i] < bk_price[b]) b = i;
        end else if (32'(seq_count - bk_arrival[i]) > 32'(seq_count - bk_arrival[b])) begin
          b = i;
        end
      end
      return b;
    endfunction

    function logic [63:0] open_depth(logic s, logic pr, logic [19:0] lim,
                                     logic [15:0] p);
      logic [63:0] sum;
      sum = '0;
      for (int i = 0; i < lob_pkg::MAX_ORDERS; i++) begin
        if (!bk_valid[i] || bk_side[i] == s || bk_owner[i] == p) continue;
        if (!does_cross(s, pr, lim, bk_price[i])) continue;
        sum += 64'(32'(bk_size[i] - bk_filled[i]));
      end
      return sum;
    endfunction

    function void enter_order(logic [31:0] c, logic [15:0] p, logic s,
                              logic [2:0] ty, logic pr, logic [19:0] px,
                              logic [31:0] q);
      logic [31:0] done, arr, mrem, t;
      int b, i;
      done = '0;
      if (lookup(c) >= 0) begin
        push_event(lob_pkg::EV_REJECT, c, 0, 0, 0, 0, lob_pkg::ST_REJECTED,
                   lob_pkg::RR_DUPLICATE);
        return;
      end
      if (ty == lob_pkg::OT_POST_ONLY) begin
        b = best_maker(s);
        if (b >= 0 && does_cross(s, pr, px, bk_price[b])) begin
          push_event(lob_pkg::EV_REJECT, c, 0, 0, 0, 0, lob_pkg::ST_REJECTED,
                     lob_pkg::RR_POST_CROSS);
          return;
        end
      end
      if (ty == lob_pkg::OT_FOK && open_depth(s, pr, px, p) < 64'(q)) begin
        push_event(lob_pkg::EV_REJECT, c, 0, 0, 0, 0, lob_pkg::ST_REJECTED,
                   lob_pkg::RR_FOK);
        return;
      end
      seq_count++;
      arr = seq_count;
      if (ty != lob_pkg::OT_POST_ONLY) begin
        while (done < q) begin
          b = best_maker(s);
          if (b < 0 || !does_cross(s, pr, px, bk_price[b])) break;
          if (bk_owner[b] == p) begin
            bk_valid[b] = 1'b0;
            push_event(lob_pkg::EV_CANCEL, bk_cid[b], 0, 0, 0, 0, lob_pkg::ST_CANCELLED,
                       lob_pkg::RR_NONE);
            continue;
          end
          mrem = bk_size[b] - bk_filled[b];
          t = q - done;
          if (mrem < t) t = mrem;
          bk_filled[b] += t;
          done += t;
          push_event(lob_pkg::EV_FILL, c, bk_cid[b], bk_price[b], t, s, lob_pkg::ST_NEW,
                     lob_pkg::RR_NONE);
          if (bk_filled[b] == bk_size[b]) bk_valid[b] = 1'b0;
        end
      end
      if (done == q) begin
        push_event(lob_pkg::EV_ACK, c, 0, 0, 0, 0, lob_pkg::ST_FILLED, lob_pkg::RR_NONE);
        return;
      end
      if ((ty == lob_pkg::OT_LIMIT || ty >= lob_pkg::OT_POST_ONLY) && pr) begin
        for (i = 0; i < lob_pkg::MAX_ORDERS; i++) if (!bk_valid[i]) break;
        if (i >= lob_pkg::MAX_ORDERS) begin
          push_event(lob_pkg::EV_REJECT, c, 0, 0, 0, 0, lob_pkg::ST_REJECTED,
                     lob_pkg::RR_BOOK_FULL);
          return;
        end
        bk_valid[i] = 1'b1; bk_cid[i] = c; bk_owner[i] = p; bk_side[i] = s;
        bk_price[i] = px; bk_size[i] = q; bk_filled[i] = done;
        bk_post[i] = (ty == lob_pkg::OT_POST_ONLY); bk_arrival[i] = arr;
        push_event(lob_pkg::EV_ACK, c, 0, 0, 0, 0,
                   done > 0 ? lob_pkg::ST_PARTIAL : lob_pkg::ST_NEW, lob_pkg::RR_NONE);
      end else begin
        push_event(lob_pkg::EV_CANCEL, c, 0, 0, 0, 0, lob_pkg::ST_CANCELLED,
                   lob_pkg::RR_NONE);
      end
    endfunction

    function void note_request(request_t r);
      int s;
      logic [19:0] oldp;
      int first;
      batch = 0;
      first = pending_events.size();
      if (r.op == lob_pkg::OP_SUBMIT) begin
        enter_order(r.cid, r.part, r.side, r.otype, r.priced, r.price, r.qty);
      end else if (r.op == lob_pkg::OP_CANCEL || r.op == lob_pkg::OP_REPLACE) begin
        s = lookup(r.cid);
        if (s < 0 || bk_owner[s] != r.part) begin
          push_event(lob_pkg::EV_REJECT, r.cid, 0, 0, 0, 0, lob_pkg::ST_REJECTED,
                     lob_pkg::RR_UNKNOWN);
        end else if (r.op == lob_pkg::OP_CANCEL) begin
          bk_valid[s] = 1'b0;
          push_event(lob_pkg::EV_CANCEL, r.cid, 0, 0, 0, 0, lob_pkg::ST_CANCELLED,
                     lob_pkg::RR_NONE);
        end else begin
          oldp = bk_price[s];
          if ((!r.priced || r.price == oldp) && r.qty > bk_filled[s] &&
              r.qty <= bk_size[s]) begin
            bk_size[s] = r.qty;
            push_event(lob_pkg::EV_ACK, r.cid, 0, 0, 0, 0,
                       bk_filled[s] > 0 ? lob_pkg::ST_PARTIAL : lob_pkg::ST_NEW,
                       lob_pkg::RR_NONE);
          end else begin
            bk_valid[s] = 1'b0;
            push_event(lob_pkg::EV_CANCEL, r.cid, 0, 0, 0, 0, lob_pkg::ST_CANCELLED,
                       lob_pkg::RR_NONE);
            enter_order(r.ncid, r.part, bk_side[s],
                        bk_post[s] ? lob_pkg::OT_POST_ONLY : lob_pkg::OT_LIMIT,
                        1'b1, r.priced ? r.price : oldp, r.qty);
          end
        end
      end
      if (pending_events.size() > first)
        pending_events[pending_events.size() - 1].last = 1'b1;
    endfunction

    function void check_event(book_event_t a);
      book_event_t e;
      if (pending_events.size() == 0) begin
        $error("unexpected event kind=%0d seq=%0d", a.kind, a.seq);
        errors++;
        return;
      end
      e = pending_events[0];
      pending_events.delete(0);
      if (a.kind !== e.kind) begin
        $error("event_kind exp %0d got %0d", e.kind, a.kind); errors++;
      end
      if (a.seq !== e.seq) begin
        $error("event_seq exp %0d got %0d", e.seq, a.seq); errors++;
      end
      if (a.cid !== e.cid) begin
        $error("event_client_id exp %0h got %0h", e.cid, a.cid); errors++;
      end
      if (a.maker !== e.maker) begin
        $error("maker_id exp %0h got %0h", e.maker, a.maker); errors++;
      end
      if (a.price !== e.price) begin
        $error("trade_price exp %0d got %0d", e.price, a.price); errors++;
      end
      if (a.qty !== e.qty) begin
        $error("trade_quantity exp %0d got %0d", e.qty, a.qty); errors++;
      end
      if (a.tside !== e.tside) begin
        $error("aggressor_side exp %0d got %0d", e.tside, a.tside); errors++;
      end
      if (a.status !== e.status) begin
        $error("order_status exp %0d got %0d", e.status, a.status); errors++;
      end
      if (a.reason !== e.reason) begin
        $error("reject_reason exp %0d got %0d", e.reason, a.reason); errors++;
      end
      if (a.last !== e.last) begin
        $error("last exp %0d got %0d", e.last, a.last); errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_op = '0;
  logic [31:0] in_client_id = '0;
  logic [31:0] in_new_client_id = '0;
  logic [15:0] in_participant = '0;
  logic        in_side = 1'b0;
  logic [2:0]  in_order_type = '0;
  logic [19:0] in_price = '0;
  logic        in_price_given = 1'b0;
  logic [31:0] in_quantity = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [1:0]  out_event_kind;
  logic [31:0] out_event_seq;
  logic [31:0] out_event_client_id;
  logic [31:0] out_maker_id;
  logic [19:0] out_trade_price;
  logic [31:0] out_trade_quantity;
  logic        out_aggressor_side;
  logic [2:0]  out_order_status;
  logic [2:0]  out_reject_reason;
  logic        out_last;

  limit_order_book_matcher_core uut (.*);

  always #1 clk = ~clk;

  book_scoreboard board = new();
  bit  calm_phase = 1'b0;
  bit  hold_receiver = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_count = 0;
  int  quiet_cycles = 0;
  logic [31:0] id_pool[$];

  localparam int QUIET_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  always @(posedge clk) begin
    book_event_t a;
    if (rst_n && out_valid && !out_stall) begin
      a.kind = out_event_kind; a.seq = out_event_seq; a.cid = out_event_client_id;
      a.maker = out_maker_id; a.price = out_trade_price;
      a.qty = out_trade_quantity; a.tside = out_aggressor_side;
      a.status = out_order_status; a.reason = out_reject_reason; a.last = out_last;
      board.check_event(a);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_receiver && !hold_done) begin
      hold_done <= 1'b1;
      hold_count <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_count != 0) begin
      hold_count <= hold_count - 1;
      out_stall <= 1'b1;
    end else if (calm_phase) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 30);
    end
  end

  task automatic send_request(request_t r);
    @(negedge clk);
    while (!calm_phase && $urandom_range(99) < 30) @(negedge clk);
    in_valid <= 1'b1;
    in_op <= r.op; in_client_id <= r.cid; in_new_client_id <= r.ncid;
    in_participant <= r.part; in_side <= r.side; in_order_type <= r.otype;
    in_price <= r.price; in_price_given <= r.priced; in_quantity <= r.qty;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(r);
    if (r.op == lob_pkg::OP_SUBMIT) id_pool.insert(id_pool.size(), r.cid);
    if (r.op == lob_pkg::OP_REPLACE) id_pool.insert(id_pool.size(), r.ncid);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (board.pending_events.size() != 0) @(negedge clk);
    repeat (lob_pkg::MAX_ORDERS * 4) @(negedge clk);
  endtask

  function automatic request_t make_req(logic [1:0] op, logic [31:0] cid,
      logic [31:0] ncid, logic [15:0] part, logic side, logic [2:0] ty,
      logic [19:0] px, logic pr, logic [31:0] q);
    request_t r;
    r.op = op; r.cid = cid; r.ncid = ncid; r.part = part; r.side = side;
    r.otype = ty; r.price = px; r.priced = pr; r.qty = q;
    return r;
  endfunction

  function automatic request_t random_req(bit noisy);
    request_t r;
    logic [31:0] pick;
    pick = id_pool.size() ? id_pool[$urandom_range(id_pool.size() - 1)] : 32'd0;
    r.op = ($urandom_range(99) < 70) ? lob_pkg::OP_SUBMIT : 2'($urandom_range(1, 2));
    if (noisy) r.op = 2'($urandom_range(3));
    r.cid = (r.op == lob_pkg::OP_SUBMIT && $urandom_range(9) != 0) ? $urandom() : pick;
    if (noisy && $urandom_range(1)) r.cid = $urandom();
    r.ncid = ($urandom_range(3) == 0) ? pick : $urandom();
    r.part = noisy ? 16'($urandom()) :
                     {1'($urandom_range(1)), 13'b0, 2'($urandom_range(3))};
    r.side = 1'($urandom_range(1));
    r.otype = noisy ? 3'($urandom_range(7)) : 3'($urandom_range(4));
    r.price = noisy ? 20'($urandom()) : 20'(1000 + $urandom_range(8));
    if (!noisy && $urandom_range(9) == 0) r.price = $urandom_range(1) ? 20'hFFFFF : 20'h0;
    r.priced = ($urandom_range(9) != 0);
    r.qty = noisy ? $urandom() : 32'($urandom_range(1, 40));
    if ($urandom_range(19) == 0) r.qty = $urandom_range(1) ? 32'hFFFFFFFF : 32'h0;
    return r;
  endfunction

  initial begin
    request_t r;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    send_request(make_req(lob_pkg::OP_SUBMIT, 32'h1, 0, 16'h1, 1'b1, lob_pkg::OT_LIMIT,
                          20'd100, 1'b1, 32'd10));
    send_request(make_req(lob_pkg::OP_SUBMIT, 32'h2, 0, 16'h2, 1'b1, lob_pkg::OT_LIMIT,
                          20'd100, 1'b1, 32'd5));
    send_request(make_req(lob_pkg::OP_SUBMIT, 32'h3, 0, 16'h3, 1'b1, lob_pkg::OT_LIMIT,
                          20'd99, 1'b1, 32'd5));
    send_request(make_req(lob_pkg::OP_SUBMIT, 32'h1, 0, 16'h1, 1'b0, lob_pkg::OT_LIMIT,
                          20'd50, 1'b1, 32'd1));
    send_request(make_req(lob_pkg::OP_SUBMIT, 32'h4, 0, 16'h4, 1'b0, lob_pkg::OT_POST_ONLY,
                          20'd99, 1'b1, 32'd1));
    send_request(make_req(lob_pkg::OP_SUBMIT, 32'h5, 0, 16'h4, 1'b0, lob_pkg::OT_FOK,
                          20'd100, 1'b1, 32'd100));
    send_request(make_req(lob_pkg::OP_SUBMIT, 32'h6, 0, 16'h4, 1'b0, lob_pkg::OT_FOK,
                          20'd100, 1'b1, 32'd12));
    send_request(make_req(lob_pkg::OP_SUBMIT, 32'h7, 0, 16'h2, 1'b0, lob_pkg::OT_IOC,
                          20'd100, 1'b1, 32'd20));
    send_request(make_req(lob_pkg::OP_SUBMIT, 32'h8, 0, 16'h5, 1'b0, lob_pkg::OT_MARKET,
                          20'd0, 1'b0, 32'd1));
    send_request(make_req(lob_pkg::OP_SUBMIT, 32'h9, 0, 16'h5, 1'b1, lob_pkg::OT_RSVD_HI,
                          20'hFFFFF, 1'b1, 32'hFFFFFFFF));
    send_request(make_req(lob_pkg::OP_SUBMIT, 32'hA, 0, 16'h5, 1'b0, lob_pkg::OT_LIMIT,
                          20'd0, 1'b0, 32'd3));
    send_request(make_req(lob_pkg::OP_SUBMIT, 32'hB, 0, 16'h6, 1'b0, lob_pkg::OT_POST_ONLY,
                          20'd5, 1'b0, 32'd3));
    send_request(make_req(lob_pkg::OP_SUBMIT, 32'hC, 0, 16'h6, 1'b0, lob_pkg::OT_LIMIT,
                          20'd5, 1'b1, 32'd0));
    send_request(make_req(lob_pkg::OP_SUBMIT, 32'hD, 0, 16'hFFFF, 1'b0, lob_pkg::OT_RSVD_LO,
                          20'd7, 1'b1, 32'd9));
    send_request(make_req(lob_pkg::OP_CANCEL, 32'hD, 0, 16'h1, 1'b0, 0, 0, 0, 0));
    send_request(make_req(lob_pkg::OP_REPLACE, 32'hD, 32'hE, 16'hFFFF, 1'b0, 0, 20'd7, 1'b1,
                          32'd4));
    send_request(make_req(lob_pkg::OP_REPLACE, 32'hD, 32'hE, 16'hFFFF, 1'b0, 0, 20'd8, 1'b0,
                          32'd4));
    send_request(make_req(lob_pkg::OP_REPLACE, 32'hD, 32'hE, 16'hFFFF, 1'b0, 0, 20'd8, 1'b1,
                          32'd4));
    send_request(make_req(lob_pkg::OP_CANCEL, 32'hE, 0, 16'hFFFF, 1'b0, 0, 0, 0, 0));
    send_request(make_req(lob_pkg::OP_CANCEL, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 1'b0, 0, 0, 0,
                          0));
    send_request(make_req(lob_pkg::OP_NONE, 32'h55, 0, 0, 1'b1, 0, 0, 0, 0));
    wait_drained();

    for (int i = 0; i < 34; i++)
      send_request(make_req(lob_pkg::OP_SUBMIT, 32'h1000 + i, 0, 16'h7, 1'b0,
                            lob_pkg::OT_LIMIT, 20'd10, 1'b1, 32'd1));
    hold_receiver = 1'b1;
    for (int i = 0; i < 3; i++) send_request(random_req(1'b0));
    wait_drained();

    send_request(make_req(lob_pkg::OP_SUBMIT, 32'h2000, 0, 16'h8, 1'b1, lob_pkg::OT_MARKET,
                          20'd0, 1'b0, 32'hFFFFFFFF));
    wait_drained();

    for (int i = 0; i < 100; i++) begin
      calm_phase = (i >= 30 && i < 70);
      r = random_req($urandom_range(9) == 0);
      send_request(r);
    end
    calm_phase = 1'b0;
    wait_drained();

    if (board.errors == 0 && board.pending_events.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
